/* rtl/lav_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int NORM_WIDTH      = 64;
   localparam int UNIT_WIDTH      = 32;
   localparam int MUL_WIDTH       = 33;
   localparam int PROD_WIDTH      = 2 * MUL_WIDTH;
   localparam int SPLIT_BITS      = 16;
   localparam int TERM_WIDTH      = PROD_WIDTH + SPLIT_BITS + 2;
   localparam int ACC_WIDTH       = 64;

   localparam logic [1:0] ROW_RIGHT = 2'd0;
   localparam logic [1:0] ROW_UP    = 2'd1;
   localparam logic [1:0] ROW_FWD   = 2'd2;

   localparam logic [1:0] LAST_TERM  = 2'd2;
   localparam logic [2:0] CROSS_LAST = 3'd5;

   localparam logic signed [ACC_WIDTH-1:0] ONE_Q30  = 64'sd1073741824;
   localparam logic signed [ACC_WIDTH-1:0] HALF_Q30 = 64'sd536870912;
   localparam logic signed [ACC_WIDTH-1:0] OUT_MAX  = 64'sd2147483647;
   localparam logic signed [ACC_WIDTH-1:0] OUT_MIN  = -64'sd2147483648;

   typedef struct packed {
      logic done;
      logic ok;
   } norm_stat_type;

   typedef struct packed {
      logic [1:0] row;
      logic [1:0] term;
      logic       half;
   } dot_tag_type;

   function automatic logic signed [UNIT_WIDTH-1:0] sat32(
      input logic signed [ACC_WIDTH-1:0] x);
      logic signed [ACC_WIDTH-1:0] y;
      y = x;
      if (x > OUT_MAX) y = OUT_MAX;
      if (x < OUT_MIN) y = OUT_MIN;
      return y[UNIT_WIDTH-1:0];
   endfunction

   // round a Q4.60 value to Q2.30 and keep it within one
   function automatic logic signed [UNIT_WIDTH-1:0] round_unit(
      input logic signed [ACC_WIDTH-1:0] x);
      logic signed [ACC_WIDTH-1:0] y;
      y = (x + HALF_Q30) >>> 30;
      if (y > ONE_Q30) y = ONE_Q30;
      if (y < -ONE_Q30) y = -ONE_Q30;
      return y[UNIT_WIDTH-1:0];
   endfunction

   // operand positions of the six products of a cross product
   function automatic logic [1:0] cross_ia(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0:    r = 2'd1;
         3'd1:    r = 2'd2;
         3'd2:    r = 2'd2;
         3'd3:    r = 2'd0;
         3'd4:    r = 2'd0;
         3'd5:    r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] cross_ib(input logic [2:0] k);
      logic [1:0] r;
      case (k)
         3'd0:    r = 2'd2;
         3'd1:    r = 2'd1;
         3'd2:    r = 2'd0;
         3'd3:    r = 2'd2;
         3'd4:    r = 2'd1;
         3'd5:    r = 2'd0;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/lav_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module lav_front #(
   parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [COORD_WIDTH-1:0] req_eye_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_eye_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_eye_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_up_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_up_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_up_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_target_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_target_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_target_z,
   output logic                               q_valid,
   input  wire logic                          q_ready,
   output logic signed [COORD_WIDTH-1:0]      q_eye [3],
   output logic signed [COORD_WIDTH-1:0]      q_up [3],
   output logic signed [COORD_WIDTH:0]        q_dir [3]
);

   localparam int PW = $clog2(lav_pkg::QUEUE_DEPTH);
   localparam int CW = PW + 1;
   localparam logic [CW-1:0] FULL = CW'(lav_pkg::QUEUE_DEPTH);

   logic signed [COORD_WIDTH-1:0] eye_ff [lav_pkg::QUEUE_DEPTH][3];
   logic signed [COORD_WIDTH-1:0] up_ff  [lav_pkg::QUEUE_DEPTH][3];
   logic signed [COORD_WIDTH:0]   dir_ff [lav_pkg::QUEUE_DEPTH][3];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic push, pop;
   logic signed [COORD_WIDTH-1:0] eye_w [3];
   logic signed [COORD_WIDTH-1:0] tgt_w [3];

   assign eye_w[0] = req_eye_x;
   assign eye_w[1] = req_eye_y;
   assign eye_w[2] = req_eye_z;
   assign tgt_w[0] = req_target_x;
   assign tgt_w[1] = req_target_y;
   assign tgt_w[2] = req_target_z;

   assign req_ready = (cnt_ff != FULL);
   assign q_valid   = (cnt_ff != '0);
   assign push      = req_valid & req_ready;
   assign pop       = q_valid & q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(lav_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(lav_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // the view direction is formed on entry so the back end starts on it at once
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < 3; i++) begin
            eye_ff[wr_ptr_ff][i] <= eye_w[i];
            dir_ff[wr_ptr_ff][i] <= (COORD_WIDTH + 1)'(tgt_w[i]) -
                                    (COORD_WIDTH + 1)'(eye_w[i]);
         end
         up_ff[wr_ptr_ff][0] <= req_up_x;
         up_ff[wr_ptr_ff][1] <= req_up_y;
         up_ff[wr_ptr_ff][2] <= req_up_z;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_eye[i] = eye_ff[rd_ptr_ff][i];
         q_up[i]  = up_ff[rd_ptr_ff][i];
         q_dir[i] = dir_ff[rd_ptr_ff][i];
      end
   end

endmodule

`default_nettype wire

/* rtl/lav_norm.sv */
`timescale 1ns / 1ps
`default_nettype none

module lav_norm (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      start,
   input  wire logic signed [lav_pkg::NORM_WIDTH-1:0]     vec [3],
   output lav_pkg::norm_stat_type                         stat,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]          res [3]
);

   localparam int NW = lav_pkg::NORM_WIDTH;
   localparam int UW = lav_pkg::UNIT_WIDTH;

   typedef enum logic [6:0] {
      N_IDLE  = 7'b0000001,
      N_SHIFT = 7'b0000010,
      N_SQ    = 7'b0000100,
      N_SQRT  = 7'b0001000,
      N_DSET  = 7'b0010000,
      N_DIV   = 7'b0100000,
      N_FIN   = 7'b1000000
   } norm_state_type;

   norm_state_type state_ff, state_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [NW-1:0] mag_ff [3];
   logic [NW-1:0] mag_in [3];
   logic [2:0]    neg_ff, neg_in;
   logic [NW-1:0] m_ff, m_in;
   logic [NW-1:0] sum_ff, sum_in;
   logic [59:0]   prod_ff, prod_in;
   logic [NW-1:0] root_ff, root_in;
   logic [NW-1:0] bit_ff, bit_in;
   logic [UW-1:0] len_ff, len_in;
   logic [UW-1:0] dr_ff [3];
   logic [UW-1:0] dr_in [3];
   logic [UW-1:0] dq_ff [3];
   logic [UW-1:0] dq_in [3];
   logic signed [UW-1:0] o_ff [3];
   logic signed [UW-1:0] o_in [3];
   logic          ok_ff, ok_in;

   logic [NW-1:0] smag [3];
   logic [NW-1:0] smax;
   logic [NW-1:0] trial;
   logic [29:0]   sq_src;
   logic [NW-1:0] num [3];
   logic [UW:0]   dtry [3];
   logic [UW:0]   ddif [3];
   logic          dge [3];
   logic [UW-1:0] qcap [3];

   assign stat.done = done_ff;
   assign stat.ok   = ok_ff;
   assign res       = o_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         smag[i] = vec[i][NW-1] ? NW'(-vec[i]) : NW'(vec[i]);
      end
      smax = smag[0];
      if (smag[1] > smax) smax = smag[1];
      if (smag[2] > smax) smax = smag[2];
   end

   always_comb begin
      trial = root_ff + bit_ff;
      case (cnt_ff[1:0])
         2'd0:    sq_src = mag_ff[0][29:0];
         2'd1:    sq_src = mag_ff[1][29:0];
         default: sq_src = mag_ff[2][29:0];
      endcase
      for (int i = 0; i < 3; i++) begin
         // rounding half of the length is folded into the dividend
         num[i]  = (NW'(mag_ff[i][29:0]) << 30) + NW'(root_ff[UW-1:1]);
         dtry[i] = {dr_ff[i], dq_ff[i][UW-1]};
         ddif[i] = dtry[i] - {1'b0, len_ff};
         dge[i]  = (dtry[i] >= {1'b0, len_ff});
         qcap[i] = (dq_ff[i] > UW'(lav_pkg::ONE_Q30)) ? UW'(lav_pkg::ONE_Q30) : dq_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      m_in     = m_ff;
      sum_in   = sum_ff;
      prod_in  = prod_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      len_in   = len_ff;
      dr_in    = dr_ff;
      dq_in    = dq_ff;
      o_in     = o_ff;
      ok_in    = ok_ff;
      case (state_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = vec[i][NW-1];
                  mag_in[i] = smag[i];
               end
               m_in = smax;
               if (smax == '0) begin
                  ok_in   = 1'b0;
                  done_in = 1'b1;
                  for (int i = 0; i < 3; i++) begin
                     o_in[i] = '0;
                  end
               end else begin
                  state_in = N_SHIFT;
               end
            end
         end
         N_SHIFT: begin
            // bring the largest magnitude into [2^29, 2^30)
            if (m_ff[NW-1:30] != '0) begin
               m_in = m_ff >> 1;
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else if (!m_ff[29]) begin
               m_in = m_ff << 1;
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end else begin
               state_in = N_SQ;
               cnt_in   = '0;
               sum_in   = '0;
            end
         end
         N_SQ: begin
            if (cnt_ff != 5'd3) begin
               prod_in = sq_src * sq_src;
            end
            if (cnt_ff != 5'd0) begin
               sum_in = sum_ff + NW'(prod_ff);
            end
            if (cnt_ff == 5'd3) begin
               state_in = N_SQRT;
               cnt_in   = '0;
               root_in  = '0;
               bit_in   = NW'(1) << 62;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         N_SQRT: begin
            if (sum_ff >= trial) begin
               sum_in  = sum_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (cnt_ff == 5'd31) begin
               state_in = N_DSET;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         N_DSET: begin
            len_in = root_ff[UW-1:0];
            for (int i = 0; i < 3; i++) begin
               dr_in[i] = num[i][NW-1:UW];
               dq_in[i] = num[i][UW-1:0];
            end
            cnt_in   = '0;
            state_in = N_DIV;
         end
         N_DIV: begin
            for (int i = 0; i < 3; i++) begin
               dr_in[i] = dge[i] ? ddif[i][UW-1:0] : dtry[i][UW-1:0];
               dq_in[i] = {dq_ff[i][UW-2:0], dge[i]};
            end
            if (cnt_ff == 5'd31) begin
               state_in = N_FIN;
            end
            cnt_in = cnt_ff + 1'b1;
         end
         N_FIN: begin
            for (int i = 0; i < 3; i++) begin
               o_in[i] = neg_ff[i] ? -$signed(qcap[i]) : $signed(qcap[i]);
            end
            ok_in    = 1'b1;
            done_in  = 1'b1;
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      m_ff    <= m_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      len_ff  <= len_in;
      dr_ff   <= dr_in;
      dq_ff   <= dq_in;
      o_ff    <= o_in;
   end

endmodule

`default_nettype wire

/* rtl/lav_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module lav_back #(
   parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_valid,
   output logic                                      q_ready,
   input  wire logic signed [COORD_WIDTH-1:0]        q_eye [3],
   input  wire logic signed [COORD_WIDTH-1:0]        q_up [3],
   input  wire logic signed [COORD_WIDTH:0]          q_dir [3],
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_row_index,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_elem_0,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_elem_1,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_elem_2,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_shift,
   output logic                                      rsp_degenerate,
   output logic                                      rsp_last_row
);

   localparam int UW = lav_pkg::UNIT_WIDTH;
   localparam int NW = lav_pkg::NORM_WIDTH;
   localparam int MW = lav_pkg::MUL_WIDTH;
   localparam int PW = lav_pkg::PROD_WIDTH;
   localparam int TW = lav_pkg::TERM_WIDTH;
   localparam int AW = lav_pkg::ACC_WIDTH;
   localparam int SB = lav_pkg::SPLIT_BITS;

   typedef enum logic [7:0] {
      B_IDLE = 8'b00000001,
      B_NF   = 8'b00000010,
      B_NU   = 8'b00000100,
      B_CR1  = 8'b00001000,
      B_NR   = 8'b00010000,
      B_CR2  = 8'b00100000,
      B_DOT  = 8'b01000000,
      B_HAND = 8'b10000000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic nstart_ff, nstart_in;
   logic iss_ff, iss_in;
   logic pend_ff, pend_in;
   logic [2:0] ccnt_ff, ccnt_in, pccnt_ff, pccnt_in;
   lav_pkg::dot_tag_type dtag_ff, dtag_in, pdtag_ff, pdtag_in;
   logic okf_ff, okf_in, oku_ff, oku_in, okr_ff, okr_in;

   logic signed [COORD_WIDTH-1:0] eye_ff [3];
   logic signed [COORD_WIDTH-1:0] eye_in [3];
   logic signed [COORD_WIDTH-1:0] up_ff  [3];
   logic signed [COORD_WIDTH-1:0] up_in  [3];
   logic signed [COORD_WIDTH:0]   dir_ff [3];
   logic signed [COORD_WIDTH:0]   dir_in [3];
   logic signed [UW-1:0] f_ff [3];
   logic signed [UW-1:0] f_in [3];
   logic signed [UW-1:0] un_ff [3];
   logic signed [UW-1:0] un_in [3];
   logic signed [UW-1:0] r_ff [3];
   logic signed [UW-1:0] r_in [3];
   logic signed [AW-1:0] cacc_ff [3];
   logic signed [AW-1:0] cacc_in [3];
   logic signed [AW-1:0] rsum_ff [3];
   logic signed [AW-1:0] rsum_in [3];
   logic signed [TW-1:0] tacc_ff, tacc_in;
   logic signed [PW-1:0] prod_ff, prod_in;

   logic bank_busy_ff, bank_busy_in;
   logic [1:0] bank_idx_ff, bank_idx_in;
   logic bank_deg_ff, bank_deg_in;
   logic signed [UW-1:0] bank_row_ff [3][3];
   logic signed [UW-1:0] bank_row_in [3][3];
   logic signed [UW-1:0] bank_sh_ff [3];
   logic signed [UW-1:0] bank_sh_in [3];

   logic signed [NW-1:0] nvec [3];
   lav_pkg::norm_stat_type nstat;
   logic signed [UW-1:0] nres [3];

   logic signed [UW-1:0] u_val [3];
   logic signed [UW-1:0] ca, cb;
   logic signed [AW-1:0] e64;
   logic signed [MW-1:0] opa, opb;
   logic signed [TW-1:0] tsum;
   logic ok_all;
   logic mul_state;

   lav_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (nstart_ff),
      .vec   (nvec),
      .stat  (nstat),
      .res   (nres)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (state_ff)
            B_NF:    nvec[i] = NW'(dir_ff[i]);
            B_NU:    nvec[i] = NW'(up_ff[i]);
            default: nvec[i] = cacc_ff[i];
         endcase
         u_val[i] = lav_pkg::round_unit(cacc_ff[i]);
      end
   end

   assign ok_all    = okf_ff & oku_ff & okr_ff;
   assign mul_state = (state_ff == B_CR1) || (state_ff == B_CR2) || (state_ff == B_DOT);

   // operand select for the shared multiplier
   always_comb begin
      ca  = '0;
      cb  = '0;
      e64 = AW'(eye_ff[dtag_ff.term]);
      case (state_ff)
         B_CR1: begin
            ca = f_ff[lav_pkg::cross_ia(ccnt_ff)];
            cb = un_ff[lav_pkg::cross_ib(ccnt_ff)];
         end
         B_CR2: begin
            ca = r_ff[lav_pkg::cross_ia(ccnt_ff)];
            cb = f_ff[lav_pkg::cross_ib(ccnt_ff)];
         end
         B_DOT: begin
            case (dtag_ff.row)
               lav_pkg::ROW_RIGHT: ca = r_ff[dtag_ff.term];
               lav_pkg::ROW_UP:    ca = u_val[dtag_ff.term];
               default:            ca = f_ff[dtag_ff.term];
            endcase
         end
         default: begin
            ca = '0;
         end
      endcase
      opa = MW'(ca);
      if (state_ff == B_DOT) begin
         // coordinate split into a signed high part and an unsigned low part
         opb = dtag_ff.half ? $signed({{(MW - SB){1'b0}}, e64[SB-1:0]}) : MW'(e64 >>> SB);
      end else begin
         opb = MW'(cb);
      end
      prod_in = opa * opb;
   end

   always_comb begin
      state_in     = state_ff;
      nstart_in    = 1'b0;
      iss_in       = iss_ff;
      pend_in      = iss_ff & mul_state;
      ccnt_in      = ccnt_ff;
      pccnt_in     = ccnt_ff;
      dtag_in      = dtag_ff;
      pdtag_in     = dtag_ff;
      okf_in       = okf_ff;
      oku_in       = oku_ff;
      okr_in       = okr_ff;
      eye_in       = eye_ff;
      up_in        = up_ff;
      dir_in       = dir_ff;
      f_in         = f_ff;
      un_in        = un_ff;
      r_in         = r_ff;
      cacc_in      = cacc_ff;
      rsum_in      = rsum_ff;
      tacc_in      = tacc_ff;
      tsum         = tacc_ff + TW'(prod_ff);
      bank_busy_in = bank_busy_ff;
      bank_idx_in  = bank_idx_ff;
      bank_deg_in  = bank_deg_ff;
      bank_row_in  = bank_row_ff;
      bank_sh_in   = bank_sh_ff;
      q_ready      = 1'b0;

      // issue side of the multiplier
      if (iss_ff) begin
         if (state_ff == B_DOT) begin
            if (!dtag_ff.half) begin
               dtag_in.half = 1'b1;
            end else begin
               dtag_in.half = 1'b0;
               if (dtag_ff.term == lav_pkg::LAST_TERM) begin
                  dtag_in.term = '0;
                  dtag_in.row  = dtag_ff.row + 1'b1;
                  if (dtag_ff.row == lav_pkg::ROW_FWD) begin
                     iss_in = 1'b0;
                  end
               end else begin
                  dtag_in.term = dtag_ff.term + 1'b1;
               end
            end
         end else if (mul_state) begin
            if (ccnt_ff == lav_pkg::CROSS_LAST) begin
               iss_in = 1'b0;
            end else begin
               ccnt_in = ccnt_ff + 1'b1;
            end
         end
      end

      // accumulate side, on the product registered in the previous cycle
      if (pend_ff) begin
         if (state_ff == B_DOT) begin
            if (!pdtag_ff.half) begin
               tacc_in = (TW'(prod_ff) <<< SB) + TW'(lav_pkg::HALF_Q30);
            end else begin
               rsum_in[pdtag_ff.row] = rsum_ff[pdtag_ff.row] + AW'(tsum >>> 30);
            end
         end else if (pccnt_ff[0]) begin
            cacc_in[pccnt_ff[2:1]] = cacc_ff[pccnt_ff[2:1]] - AW'(prod_ff);
         end else begin
            cacc_in[pccnt_ff[2:1]] = cacc_ff[pccnt_ff[2:1]] + AW'(prod_ff);
         end
      end

      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_ready   = 1'b1;
               eye_in    = q_eye;
               up_in     = q_up;
               dir_in    = q_dir;
               nstart_in = 1'b1;
               state_in  = B_NF;
            end
         end
         B_NF: begin
            if (nstat.done) begin
               f_in      = nres;
               okf_in    = nstat.ok;
               nstart_in = 1'b1;
               state_in  = B_NU;
            end
         end
         B_NU: begin
            if (nstat.done) begin
               un_in    = nres;
               oku_in   = nstat.ok;
               iss_in   = 1'b1;
               ccnt_in  = '0;
               state_in = B_CR1;
               for (int i = 0; i < 3; i++) begin
                  cacc_in[i] = '0;
               end
            end
         end
         B_CR1: begin
            if (!iss_ff && !pend_ff) begin
               nstart_in = 1'b1;
               state_in  = B_NR;
            end
         end
         B_NR: begin
            if (nstat.done) begin
               r_in     = nres;
               okr_in   = nstat.ok;
               iss_in   = 1'b1;
               ccnt_in  = '0;
               state_in = B_CR2;
               for (int i = 0; i < 3; i++) begin
                  cacc_in[i] = '0;
               end
            end
         end
         B_CR2: begin
            if (!iss_ff && !pend_ff) begin
               iss_in   = 1'b1;
               dtag_in  = '0;
               state_in = B_DOT;
               for (int i = 0; i < 3; i++) begin
                  rsum_in[i] = '0;
               end
            end
         end
         B_DOT: begin
            if (!iss_ff && !pend_ff) begin
               state_in = B_HAND;
            end
         end
         B_HAND: begin
            if (!bank_busy_ff) begin
               bank_busy_in = 1'b1;
               bank_idx_in  = lav_pkg::ROW_RIGHT;
               bank_deg_in  = !ok_all;
               for (int i = 0; i < 3; i++) begin
                  bank_row_in[lav_pkg::ROW_RIGHT][i] = ok_all ? r_ff[i] : '0;
                  bank_row_in[lav_pkg::ROW_UP][i]    = ok_all ? u_val[i] : '0;
                  bank_row_in[lav_pkg::ROW_FWD][i]   = ok_all ? -f_ff[i] : '0;
               end
               bank_sh_in[lav_pkg::ROW_RIGHT] =
                  ok_all ? lav_pkg::sat32(-rsum_ff[lav_pkg::ROW_RIGHT]) : '0;
               bank_sh_in[lav_pkg::ROW_UP] =
                  ok_all ? lav_pkg::sat32(-rsum_ff[lav_pkg::ROW_UP]) : '0;
               bank_sh_in[lav_pkg::ROW_FWD] =
                  ok_all ? lav_pkg::sat32(rsum_ff[lav_pkg::ROW_FWD]) : '0;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      // the row bank drains while the next request is worked on
      if (bank_busy_ff && rsp_ready) begin
         if (bank_idx_ff == lav_pkg::ROW_FWD) begin
            bank_busy_in = 1'b0;
            bank_idx_in  = lav_pkg::ROW_RIGHT;
         end else begin
            bank_idx_in = bank_idx_ff + 1'b1;
         end
      end
   end

   assign rsp_valid      = bank_busy_ff;
   assign rsp_row_index  = bank_idx_ff;
   assign rsp_elem_0     = bank_row_ff[bank_idx_ff][0];
   assign rsp_elem_1     = bank_row_ff[bank_idx_ff][1];
   assign rsp_elem_2     = bank_row_ff[bank_idx_ff][2];
   assign rsp_shift      = bank_sh_ff[bank_idx_ff];
   assign rsp_degenerate = bank_deg_ff;
   assign rsp_last_row   = (bank_idx_ff == lav_pkg::ROW_FWD);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         nstart_ff    <= 1'b0;
         iss_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         ccnt_ff      <= '0;
         pccnt_ff     <= '0;
         dtag_ff      <= '0;
         pdtag_ff     <= '0;
         bank_busy_ff <= 1'b0;
         bank_idx_ff  <= lav_pkg::ROW_RIGHT;
      end else begin
         state_ff     <= state_in;
         nstart_ff    <= nstart_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
         ccnt_ff      <= ccnt_in;
         pccnt_ff     <= pccnt_in;
         dtag_ff      <= dtag_in;
         pdtag_ff     <= pdtag_in;
         bank_busy_ff <= bank_busy_in;
         bank_idx_ff  <= bank_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      okf_ff      <= okf_in;
      oku_ff      <= oku_in;
      okr_ff      <= okr_in;
      eye_ff      <= eye_in;
      up_ff       <= up_in;
      dir_ff      <= dir_in;
      f_ff        <= f_in;
      un_ff       <= un_in;
      r_ff        <= r_in;
      cacc_ff     <= cacc_in;
      rsum_ff     <= rsum_in;
      tacc_ff     <= tacc_in;
      prod_ff     <= prod_in;
      bank_deg_ff <= bank_deg_in;
      bank_row_ff <= bank_row_in;
      bank_sh_ff  <= bank_sh_in;
   end

endmodule

`default_nettype wire

/* rtl/look_at_view_matrix.sv */
`timescale 1ns / 1ps
`default_nettype none

// Look-at view matrix. Each request carries eye, up and target in signed
// fixed point and yields three responses, the right, up and negated forward
// rows of the view matrix (Q2.30 entries plus a saturated translation), the
// last one flagged by rsp_last_row; a zero-length direction, zero up vector
// or up parallel to the view gives three all-zero rows with rsp_degenerate set.
// The back end runs a shared normalize unit three times, each run made of
// alignment shifts, a sum of squares, a square root and a three-lane divide,
// with a zero vector reported straight from idle. Then come two cross products
// and the translation dot products, all on one 33x33 multiplier, and a
// hand-over of the rows before the next request is taken. The front end holds
// two requests in a queue and the three rows of a finished request drain from
// their own bank while the next one runs.
module look_at_view_matrix #(
   parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]        req_eye_x,
   input  wire logic signed [COORD_WIDTH-1:0]        req_eye_y,
   input  wire logic signed [COORD_WIDTH-1:0]        req_eye_z,
   input  wire logic signed [COORD_WIDTH-1:0]        req_up_x,
   input  wire logic signed [COORD_WIDTH-1:0]        req_up_y,
   input  wire logic signed [COORD_WIDTH-1:0]        req_up_z,
   input  wire logic signed [COORD_WIDTH-1:0]        req_target_x,
   input  wire logic signed [COORD_WIDTH-1:0]        req_target_y,
   input  wire logic signed [COORD_WIDTH-1:0]        req_target_z,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_row_index,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_elem_0,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_elem_1,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_elem_2,
   output logic signed [lav_pkg::UNIT_WIDTH-1:0]     rsp_shift,
   output logic                                      rsp_degenerate,
   output logic                                      rsp_last_row
);

   logic q_valid;
   logic q_ready;
   logic signed [COORD_WIDTH-1:0] q_eye [3];
   logic signed [COORD_WIDTH-1:0] q_up [3];
   logic signed [COORD_WIDTH:0]   q_dir [3];

   lav_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_eye_x    (req_eye_x),
      .req_eye_y    (req_eye_y),
      .req_eye_z    (req_eye_z),
      .req_up_x     (req_up_x),
      .req_up_y     (req_up_y),
      .req_up_z     (req_up_z),
      .req_target_x (req_target_x),
      .req_target_y (req_target_y),
      .req_target_z (req_target_z),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_eye        (q_eye),
      .q_up         (q_up),
      .q_dir        (q_dir)
   );

   lav_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_eye          (q_eye),
      .q_up           (q_up),
      .q_dir          (q_dir),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_row_index  (rsp_row_index),
      .rsp_elem_0     (rsp_elem_0),
      .rsp_elem_1     (rsp_elem_1),
      .rsp_elem_2     (rsp_elem_2),
      .rsp_shift      (rsp_shift),
      .rsp_degenerate (rsp_degenerate),
      .rsp_last_row   (rsp_last_row)
   );

endmodule

`default_nettype wire

/* tb/look_at_view_matrix_tb.sv */
`timescale 1ns / 1ps

module look_at_view_matrix_tb;

   typedef struct {
      logic signed [31:0] eye [3];
      logic signed [31:0] up  [3];
      logic signed [31:0] tgt [3];
   } camera_type;

   typedef struct packed {
      logic [1:0]         row;
      logic signed [31:0] e0;
      logic signed [31:0] e1;
      logic signed [31:0] e2;
      logic signed [31:0] sh;
      logic               degen;
      logic               last;
   } view_row_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [31:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_elem_0, rsp_elem_1, rsp_elem_2, rsp_shift;
   logic rsp_degenerate, rsp_last_row;

   camera_type   cameras_pending [$];
   view_row_type rows_expected [$];
   int        n_sent = 0;
   int        n_rows = 0;
   int        n_mismatch = 0;
   int        quiet_cycles = 0;
   logic      req_fire = 1'b0;
   logic      stim_done = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   look_at_view_matrix u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_eye_x(req_eye_x), .req_eye_y(req_eye_y), .req_eye_z(req_eye_z),
      .req_up_x(req_up_x), .req_up_y(req_up_y), .req_up_z(req_up_z),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_row_index(rsp_row_index),
      .rsp_elem_0(rsp_elem_0), .rsp_elem_1(rsp_elem_1), .rsp_elem_2(rsp_elem_2),
      .rsp_shift(rsp_shift), .rsp_degenerate(rsp_degenerate),
      .rsp_last_row(rsp_last_row)
   );

   function automatic longint unsigned sqrt_floor(input longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // scale to unit length in Q2.30, zero vector reports failure
   function automatic bit unit_vec(input longint v [3], output longint o [3]);
      longint unsigned a [3];
      longint unsigned m, len, q;
      bit neg [3];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         a[i] = neg[i] ? -v[i] : v[i];
         if (a[i] > m) m = a[i];
         o[i] = 0;
      end
      if (m == 0) return 1'b0;
      while (m >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
         m = m >> 1;
      end
      while (m < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
         m = m << 1;
      end
      len = sqrt_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int i = 0; i < 3; i++) begin
         q = ((a[i] << 30) + (len >> 1)) / len;
         if (q > (64'd1 << 30)) q = 64'd1 << 30;
         o[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic void cross_prod(input longint a [3], input longint b [3],
                                      output longint o [3]);
      o[0] = a[1] * b[2] - a[2] * b[1];
      o[1] = a[2] * b[0] - a[0] * b[2];
      o[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic longint eye_dot(input longint c [3], input longint e [3]);
      longint s;
      s = 0;
      for (int i = 0; i < 3; i++) s = s + ((c[i] * e[i] + 64'sd536870912) >>> 30);
      return s;
   endfunction

   function automatic logic signed [31:0] clip32(input longint x);
      if (x > 64'sd2147483647) x = 64'sd2147483647;
      if (x < -64'sd2147483648) x = -64'sd2147483648;
      return x[31:0];
   endfunction

   task automatic predict_view_rows(input camera_type cam);
      longint eye [3], upv [3], d [3], f [3], un [3], c [3], r [3], u [3], t;
      longint rows [3][3];
      longint sh [3];
      bit ok;
      view_row_type vr;
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'(cam.eye[i]);
         upv[i] = longint'(cam.up[i]);
         d[i] = longint'(cam.tgt[i]) - eye[i];
      end
      ok = unit_vec(d, f);
      ok = unit_vec(upv, un) && ok;
      cross_prod(f, un, c);
      ok = unit_vec(c, r) && ok;
      cross_prod(r, f, c);
      for (int i = 0; i < 3; i++) begin
         t = (c[i] + 64'sd536870912) >>> 30;
         if (t > 64'sd1073741824) t = 64'sd1073741824;
         if (t < -64'sd1073741824) t = -64'sd1073741824;
         u[i] = t;
         rows[0][i] = ok ? r[i] : 0;
         rows[1][i] = ok ? u[i] : 0;
         rows[2][i] = ok ? -f[i] : 0;
      end
      sh[0] = ok ? -eye_dot(r, eye) : 0;
      sh[1] = ok ? -eye_dot(u, eye) : 0;
      sh[2] = ok ? eye_dot(f, eye) : 0;
      for (int k = 0; k < 3; k++) begin
         vr.row   = (k == 0) ? lav_pkg::ROW_RIGHT :
                    (k == 1) ? lav_pkg::ROW_UP : lav_pkg::ROW_FWD;
         vr.e0    = rows[k][0][31:0];
         vr.e1    = rows[k][1][31:0];
         vr.e2    = rows[k][2][31:0];
         vr.sh    = clip32(sh[k]);
         vr.degen = !ok;
         vr.last  = (k == 2);
         rows_expected.push_back(vr);
      end
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0:       return $urandom;
         1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         2:       return $signed($urandom_range(2000)) - 1000;
         default: return $signed($urandom_range(32'h00ffffff)) - 32'sh00800000;
      endcase
   endfunction

   function automatic camera_type rand_camera();
      camera_type cam;
      int kind;
      for (int i = 0; i < 3; i++) begin
         cam.eye[i] = rand_coord();
         cam.up[i]  = rand_coord();
         cam.tgt[i] = rand_coord();
      end
      kind = $urandom_range(99);
      if (kind < 4) begin
         cam.tgt = cam.eye;
      end else if (kind < 8) begin
         cam.up = '{0, 0, 0};
      end else if (kind < 13) begin
         // up parallel to the view direction
         for (int i = 0; i < 3; i++) begin
            cam.eye[i] = $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
            cam.tgt[i] = $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
            cam.up[i]  = (cam.tgt[i] - cam.eye[i]) * ($urandom_range(1) ? 3 : -2);
         end
      end
      return cam;
   endfunction

   function automatic camera_type make_camera(
      input logic signed [31:0] ex, ey, ez, ux, uy, uz, tx, ty, tz);
      camera_type cam;
      cam.eye = '{ex, ey, ez};
      cam.up  = '{ux, uy, uz};
      cam.tgt = '{tx, ty, tz};
      return cam;
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      cameras_pending.push_back(make_camera(0, 0, 65536, 0, 65536, 0, 0, 0, 0));
      cameras_pending.push_back(make_camera(0, 0, 0, 0, 65536, 0, 65536, 0, 0));
      cameras_pending.push_back(make_camera(5, 5, 5, 0, 1, 0, 5, 5, 5));
      cameras_pending.push_back(make_camera(1, 2, 3, 0, 0, 0, 9, 9, 9));
      cameras_pending.push_back(make_camera(0, 0, 0, 0, 0, 7, 0, 0, 65536));
      cameras_pending.push_back(make_camera(32'sh7fffffff, 32'sh7fffffff,
         32'sh7fffffff, 0, 65536, 0, -32'sh80000000, -32'sh80000000, 0));
      cameras_pending.push_back(make_camera(-32'sh80000000, -32'sh80000000,
         -32'sh80000000, -1, -1, -1, 32'sh7fffffff, 0, 32'sh7fffffff));
      cameras_pending.push_back(make_camera(32'sh7fffffff, -32'sh80000000,
         32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, -32'sh80000000,
         -32'sh80000000, 32'sh7fffffff, -32'sh80000000));
      cameras_pending.push_back(make_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
      cameras_pending.push_back(make_camera(-1, -1, -1, -1, 0, 0, 0, 0, 0));
      cameras_pending.push_back(make_camera(32'sh7fff0000, 12345, -678,
         0, 0, -32'sh80000000, 0, 0, 0));
      cameras_pending.push_back(make_camera(0, 0, 0, 65536, 65536, 65536, 3, 3, 3));
      for (int n = 0; n < 400; n++) cameras_pending.push_back(rand_camera());
      stim_done <= 1'b1;
   end

   function automatic bit idle_now(input int progress, input int lo, input int hi);
      if (progress >= lo && progress < hi) return 1'b0;
      return $urandom_range(99) < 36;
   endfunction

   task automatic cam_drive(input camera_type cam);
      req_eye_x <= cam.eye[0]; req_eye_y <= cam.eye[1]; req_eye_z <= cam.eye[2];
      req_up_x  <= cam.up[0];  req_up_y  <= cam.up[1];  req_up_z  <= cam.up[2];
      req_target_x <= cam.tgt[0];
      req_target_y <= cam.tgt[1];
      req_target_z <= cam.tgt[2];
   endtask

   // request side: advance only once the current request went through
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (cameras_pending.size() != 0 && !idle_now(n_sent, 150, 260)) begin
            cam_drive(cameras_pending.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && !idle_now(n_rows, 500, 800);
   end

   always @(posedge clock) begin
      camera_type cam;
      view_row_type got, want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            cam.eye = '{req_eye_x, req_eye_y, req_eye_z};
            cam.up  = '{req_up_x, req_up_y, req_up_z};
            cam.tgt = '{req_target_x, req_target_y, req_target_z};
            predict_view_rows(cam);
            n_sent <= n_sent + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_row_index, rsp_elem_0, rsp_elem_1, rsp_elem_2, rsp_shift,
                    rsp_degenerate, rsp_last_row};
            n_rows <= n_rows + 1;
            if (rows_expected.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected row %p", got);
            end else begin
               want = rows_expected.pop_front();
               if (got != want) begin
                  n_mismatch++;
                  if (n_mismatch <= 10) begin
                     $display("row mismatch: expected row=%0d e=%0d,%0d,%0d sh=%0d dg=%0b lr=%0b",
                        want.row, want.e0, want.e1, want.e2, want.sh, want.degen,
                        want.last);
                     $display("  actual   row=%0d e=%0d,%0d,%0d sh=%0d dg=%0b lr=%0b",
                        got.row, got.e0, got.e1, got.e2, got.sh, got.degen,
                        got.last);
                  end
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (stim_done);
      while (cameras_pending.size() != 0 || req_valid || rows_expected.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
      if (n_mismatch == 0 && rows_expected.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

endmodule
